[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property must never hold at a clock edge outside reset.
`define ASSERT_NEVER(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(prop)) else $error(msg);

`endif

[rtl/assd_pkg.sv]
package assd_pkg;

    localparam int DISPLAY_BYTES = 48;
    localparam int DIGITS        = 6;
    localparam int FRAME_BYTES   = DISPLAY_BYTES + 2;
    localparam int DISP_AW       = $clog2(DISPLAY_BYTES);
    localparam int POS_W         = $clog2(FRAME_BYTES + 2);
    localparam int LD_CNT_W      = $clog2(DISPLAY_BYTES + 1);
    localparam int SLOT_W        = 3;
    localparam int SCAN_W        = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int GROUPS        = (DISPLAY_BYTES + DIGITS - 1) / DIGITS;

    localparam logic [15:0] ADDR_RST   = 16'h0003;
    localparam logic [15:0] PERIOD_RST = 16'd16384;

    typedef enum logic [1:0] {
        OP_CLOCK = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVICE_ADDRESS = 1'b0,
        CFG_SCROLL_PERIOD  = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_LOAD
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic               accept;
        logic               tick_done;
        logic               ld_rd;
        logic [DISP_AW-1:0] ld_addr;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_tick;
        logic load_go;
    } t_stat;

    // Power-up pattern: every group of DIGITS bytes holds one bit, walking per group.
    function automatic logic [7:0] disp_reset_byte(input logic [DISP_AW-1:0] idx);
        logic [2:0] grp;
        grp = '0;
        for (int g = 1; g < GROUPS; g++) begin
            if (int'(idx) >= g * DIGITS) grp = 3'(g);
        end
        return 8'b1 << grp;
    endfunction

endpackage

[rtl/assd_ctrl.sv]
module assd_ctrl import assd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state                r_state, n_state;
    logic [LD_CNT_W-1:0]   r_ld_cnt, n_ld_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ld_cnt <= '0;
        end else begin
            r_state  <= n_state;
            r_ld_cnt <= n_ld_cnt;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ld_cnt = r_ld_cnt;
        o_cmd    = '0;
        o_busy   = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_start;
                if (i_start) begin
                    if (i_stat.is_tick) begin
                        n_state = ST_TICK;
                    end else if (i_stat.load_go) begin
                        n_state  = ST_LOAD;
                        n_ld_cnt = '0;
                    end
                end
            end
            ST_TICK: begin
                o_cmd.tick_done = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_LOAD: begin
                // the final step issues no read and drains the last registered read into the display store
                o_cmd.ld_rd   = (r_ld_cnt < LD_CNT_W'(DISPLAY_BYTES));
                o_cmd.ld_addr = r_ld_cnt[DISP_AW-1:0];
                n_ld_cnt      = r_ld_cnt + 1'b1;
                if (r_ld_cnt == LD_CNT_W'(DISPLAY_BYTES)) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/assd_datapath.sv]
module assd_datapath import assd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [1:0]            i_opcode,
    input  logic                  i_data_bit,
    input  logic                  i_clock_high,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_strobe,
    output logic [7:0]            o_segments_n,
    output logic [2:0]            o_digit_index,
    output logic                  o_digit_valid,
    output logic                  o_frame_loaded
);

    // configuration
    logic [15:0]         r_dev_addr;
    logic [15:0]         r_period;

    // receiver
    logic [POS_W-1:0]    r_byte_pos, n_byte_pos;
    logic [2:0]          r_bit_pos, n_bit_pos;
    logic [6:0]          r_shift;
    logic [7:0]          r_addr_hi, r_addr_lo;
    logic [7:0]          mem_recv [DISPLAY_BYTES];
    logic [7:0]          r_recv_q;
    logic                recv_we;
    logic [DISP_AW-1:0]  recv_waddr;
    logic [7:0]          new_byte;
    logic                byte_done;
    logic                load_go;

    // display
    logic [7:0]          mem_disp [DISPLAY_BYTES];
    logic [7:0]          r_disp_q;
    logic [DISP_AW-1:0]  r_base, n_base, rot_base, new_base;
    logic [DISP_AW:0]    base_step, phys_sum;
    logic [DISP_AW-1:0]  phys;
    logic [SCAN_W-1:0]   r_scan, n_scan, scan_inc;
    logic [SLOT_W-1:0]   r_slot, n_slot, r_tick_slot;
    logic [DISP_AW-1:0]  r_phys;
    logic                r_loaded;
    logic                do_rot;
    logic                r_ld_we;
    logic [DISP_AW-1:0]  r_ld_waddr;

    // result register
    logic                r_strobe;
    logic [7:0]          r_seg;
    logic [2:0]          r_digit;
    logic                r_dvalid;
    logic                r_floaded;

    t_opcode             op;
    logic                acc_clock, acc_start, acc_tick;

    assign op        = t_opcode'(i_opcode);
    assign acc_clock = i_cmd.accept && (op == OP_CLOCK);
    assign acc_start = i_cmd.accept && (op == OP_START);
    assign acc_tick  = i_cmd.accept && (op == OP_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= ADDR_RST;
            r_period   <= PERIOD_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_DEVICE_ADDRESS: r_dev_addr <= i_cfg_data;
                CFG_SCROLL_PERIOD:  r_period   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ---------------- receiver ----------------
    assign new_byte   = {r_shift, i_data_bit};
    assign byte_done  = (r_bit_pos == 3'd0) && (r_byte_pos < POS_W'(FRAME_BYTES));
    assign recv_we    = acc_clock && byte_done && (r_byte_pos >= POS_W'(2));
    assign recv_waddr = DISP_AW'(r_byte_pos - POS_W'(2));
    // address bytes were captured in this frame by the time the last byte arrives
    assign load_go    = (op == OP_CLOCK) && (r_bit_pos == 3'd0)
                        && (r_byte_pos == POS_W'(FRAME_BYTES - 1))
                        && (r_addr_hi == r_dev_addr[15:8])
                        && (r_addr_lo == r_dev_addr[7:0]);

    assign o_stat.is_tick = (op == OP_TICK);
    assign o_stat.load_go = load_go;

    always_comb begin
        n_bit_pos  = r_bit_pos;
        n_byte_pos = r_byte_pos;
        if (acc_clock) begin
            if (r_bit_pos != 3'd0) begin
                n_bit_pos = r_bit_pos - 3'd1;
            end else begin
                n_bit_pos = 3'd7;
                // saturate at FRAME_BYTES + 1, past the end of the frame
                if (r_byte_pos <= POS_W'(FRAME_BYTES)) n_byte_pos = r_byte_pos + 1'b1;
            end
        end else if (acc_start && i_clock_high) begin
            n_bit_pos  = 3'd7;
            n_byte_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_pos  <= 3'd7;
            r_byte_pos <= '0;
        end else begin
            r_bit_pos  <= n_bit_pos;
            r_byte_pos <= n_byte_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_clock) r_shift <= new_byte[6:0];
        if (acc_clock && byte_done && (r_byte_pos == POS_W'(0))) r_addr_hi <= new_byte;
        if (acc_clock && byte_done && (r_byte_pos == POS_W'(1))) r_addr_lo <= new_byte;
    end

    always_ff @(posedge i_clk) begin
        if (recv_we) mem_recv[recv_waddr] <= new_byte;
        if (i_cmd.ld_rd) r_recv_q <= mem_recv[i_cmd.ld_addr];
    end

    // ---------------- display ----------------
    // rotation moves a base pointer instead of the bytes
    assign scan_inc  = r_scan + 1'b1;
    assign do_rot    = acc_tick && (r_slot == '0) && (scan_inc == r_period);
    assign base_step = {1'b0, r_base} + (DISP_AW+1)'(DIGITS);
    assign rot_base  = (base_step >= (DISP_AW+1)'(DISPLAY_BYTES))
                       ? DISP_AW'(base_step - (DISP_AW+1)'(DISPLAY_BYTES))
                       : DISP_AW'(base_step);
    assign new_base  = do_rot ? rot_base : r_base;
    assign phys_sum  = {1'b0, new_base} + (DISP_AW+1)'(r_slot);
    assign phys      = (phys_sum >= (DISP_AW+1)'(DISPLAY_BYTES))
                       ? DISP_AW'(phys_sum - (DISP_AW+1)'(DISPLAY_BYTES))
                       : DISP_AW'(phys_sum);

    always_comb begin
        n_scan = r_scan;
        n_slot = r_slot;
        n_base = r_base;
        if (acc_tick) begin
            if (r_slot == '0) n_scan = do_rot ? '0 : scan_inc;
            n_slot = (r_slot == SLOT_W'(DIGITS - 1)) ? '0 : r_slot + 1'b1;
            n_base = new_base;
        end else if (i_cmd.accept && load_go) begin
            n_base = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan     <= '0;
            r_slot     <= '0;
            r_base     <= '0;
            r_loaded   <= 1'b0;
            r_ld_we    <= 1'b0;
        end else begin
            r_scan     <= n_scan;
            r_slot     <= n_slot;
            r_base     <= n_base;
            r_ld_we    <= i_cmd.ld_rd;
            if (i_cmd.accept && load_go) r_loaded <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ld_waddr <= i_cmd.ld_addr;
        if (acc_tick) begin
            r_tick_slot <= r_slot;
            r_phys      <= phys;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ld_we) mem_disp[r_ld_waddr] <= r_recv_q;
        if (acc_tick) r_disp_q <= mem_disp[phys];
    end

    // ---------------- result ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.accept && (op != OP_TICK)) || i_cmd.tick_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (op != OP_TICK)) begin
            r_seg     <= '0;
            r_digit   <= '0;
            r_dvalid  <= 1'b0;
            r_floaded <= load_go;
        end else if (i_cmd.tick_done) begin
            // entries not yet loaded show the power-up pattern
            r_seg     <= ~(r_loaded ? r_disp_q : disp_reset_byte(r_phys));
            r_digit   <= r_tick_slot;
            r_dvalid  <= 1'b1;
            r_floaded <= 1'b0;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_segments_n   = r_seg;
    assign o_digit_index  = r_digit;
    assign o_digit_valid  = r_dvalid;
    assign o_frame_loaded = r_floaded;

endmodule

[rtl/addressed_serial_scrolling_display.sv]
// Serial frame receiver driving a six-digit multiplexed display. An item is taken when start
// is high and busy is low; each item gives one result, shown for a single cycle with o_strobe,
// and the receiver cannot hold it off. Clock-edge, start and unknown items register their
// result, which appears the cycle after acceptance. A display tick reads the display memory
// into a register and passes through the ST_TICK state before its result is registered.
// The clock edge that completes a frame with a matching address keeps the block busy while
// the 48 display bytes are copied from the receive memory to the display memory,
// one byte per cycle through their single read and write ports. Configuration writes are
// always ready and must only be issued while the block is idle.
`include "assert_macros.svh"

module addressed_serial_scrolling_display import assd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_opcode,
    input  logic                  i_data_bit,
    input  logic                  i_clock_high,
    output logic                  o_strobe,
    output logic [7:0]            o_segments_n,
    output logic [2:0]            o_digit_index,
    output logic                  o_digit_valid,
    output logic                  o_frame_loaded,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    assd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    assd_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_opcode       (i_opcode),
        .i_data_bit     (i_data_bit),
        .i_clock_high   (i_clock_high),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_segments_n   (o_segments_n),
        .o_digit_index  (o_digit_index),
        .o_digit_valid  (o_digit_valid),
        .o_frame_loaded (o_frame_loaded)
    );

    `ASSERT_ALWAYS(a_plain_result, start && !busy && i_opcode != OP_TICK |=> o_strobe, "missing result after transaction")
    `ASSERT_ALWAYS(a_tick_result, start && !busy && i_opcode == OP_TICK |-> ##2 (o_strobe && o_digit_valid), "missing tick result")
    `ASSERT_NEVER(a_digit_range, o_strobe && o_digit_index >= 3'(DIGITS), "digit index out of range")
    `ASSERT_ALWAYS(a_load_busy, o_strobe && o_frame_loaded |-> busy, "frame loaded without copy sweep")

endmodule

[tb/tb_top.sv]
import assd_pkg::*;

typedef struct packed {
    logic [7:0] seg_n;
    logic [2:0] digit;
    logic       shown;
    logic       loaded;
} t_disp_result;

class display_scoreboard;
    logic [15:0]  dev_addr;
    logic [15:0]  period;
    logic [7:0]   rx_mem [FRAME_BYTES];
    int unsigned  rx_byte;
    logic [2:0]   rx_bit;
    logic [7:0]   disp_mem [DISPLAY_BYTES];
    logic [15:0]  scans;
    logic [2:0]   slot;
    t_disp_result pending [$];
    int           errors;

    function new();
        dev_addr = ADDR_RST;
        period   = PERIOD_RST;
        foreach (rx_mem[i]) rx_mem[i] = 8'h00;
        rx_byte = 0;
        rx_bit  = 3'd7;
        foreach (disp_mem[i]) disp_mem[i] = 8'h01 << ((i / DIGITS) % 8);
        scans  = '0;
        slot   = '0;
        errors = 0;
    endfunction

    function void set_reg(t_cfg_index idx, logic [15:0] val);
        case (idx)
            CFG_DEVICE_ADDRESS: dev_addr = val;
            CFG_SCROLL_PERIOD:  period   = val;
            default: ;
        endcase
    endfunction

    // Shift one bit in; return 1 when it completes a frame for this address.
    function bit shift_bit(logic d);
        if (rx_byte < FRAME_BYTES) rx_mem[rx_byte][rx_bit] = d;
        if (rx_bit != 3'd0) begin
            rx_bit--;
        end else begin
            rx_bit = 3'd7;
            // saturate past the frame so that no second load can happen
            if (rx_byte <= FRAME_BYTES) rx_byte++;
        end
        if (rx_byte == FRAME_BYTES && rx_bit == 3'd7
            && rx_mem[0] == dev_addr[15:8] && rx_mem[1] == dev_addr[7:0]) begin
            for (int i = 0; i < DISPLAY_BYTES; i++) disp_mem[i] = rx_mem[i + 2];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void scroll();
        logic [7:0] tmp [DISPLAY_BYTES];
        for (int i = 0; i < DISPLAY_BYTES; i++)
            tmp[i] = disp_mem[(i + DIGITS) % DISPLAY_BYTES];
        disp_mem = tmp;
    endfunction

    function void note_input(logic [1:0] op, logic d, logic ch);
        t_disp_result r;
        r = '0;
        case (op)
            OP_CLOCK: r.loaded = shift_bit(d);
            OP_START: begin
                if (ch) begin
                    rx_byte = 0;
                    rx_bit  = 3'd7;
                end
            end
            OP_TICK: begin
                if (slot == 3'd0) begin
                    scans++;
                    if (scans == period) begin
                        scroll();
                        scans = '0;
                    end
                end
                r.seg_n = ~disp_mem[slot];
                r.digit = slot;
                r.shown = 1'b1;
                slot = (slot == DIGITS - 1) ? 3'd0 : slot + 3'd1;
            end
            default: ;
        endcase
        pending.push_back(r);
    endfunction

    function void check_result(t_disp_result got);
        t_disp_result want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.seg_n !== want.seg_n) begin
            $display("%0t: segments_n expected %02h actual %02h", $time, want.seg_n, got.seg_n);
            errors++;
        end
        if (got.digit !== want.digit) begin
            $display("%0t: digit_index expected %0d actual %0d", $time, want.digit, got.digit);
            errors++;
        end
        if (got.shown !== want.shown) begin
            $display("%0t: digit_valid expected %b actual %b", $time, want.shown, got.shown);
            errors++;
        end
        if (got.loaded !== want.loaded) begin
            $display("%0t: frame_loaded expected %b actual %b", $time, want.loaded, got.loaded);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam logic [1:0] OP_NONE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            i_opcode;
    logic                  i_data_bit;
    logic                  i_clock_high;
    logic                  o_strobe;
    logic [7:0]            o_segments_n;
    logic [2:0]            o_digit_index;
    logic                  o_digit_valid;
    logic                  o_frame_loaded;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    display_scoreboard sb = new();
    int sender_idle = 0;

    addressed_serial_scrolling_display i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_data_bit     (i_data_bit),
        .i_clock_high   (i_clock_high),
        .o_strobe       (o_strobe),
        .o_segments_n   (o_segments_n),
        .o_digit_index  (o_digit_index),
        .o_digit_valid  (o_digit_valid),
        .o_frame_loaded (o_frame_loaded),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result({o_segments_n, o_digit_index, o_digit_valid, o_frame_loaded});
    end

    initial begin
        #1000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hold the transaction until the block takes it, idling first at random.
    task automatic issue(logic [1:0] op, logic d, logic ch);
        while ($urandom_range(0, 99) < sender_idle) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_opcode     <= op;
        i_data_bit   <= d;
        i_clock_high <= ch;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_input(op, d, ch);
    endtask

    // Wait for every result, then let a frame load run out.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_index idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_reg(idx, val);
    endtask

    task automatic write_settings(logic [15:0] addr, logic [15:0] per);
        drain();
        cfg_write(CFG_DEVICE_ADDRESS, addr);
        cfg_write(CFG_SCROLL_PERIOD, per);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic noise(int n);
        logic [1:0] op;
        for (int k = 0; k < n; k++) begin
            op = ($urandom_range(0, 1) == 0) ? OP_TICK : 2'($urandom_range(0, 3));
            issue(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Start, then clock frame bits MSB first with ticks and starts mixed in.
    task automatic send_frame(bit full, bit match);
        logic [7:0] frame [FRAME_BYTES];
        int         nbits;
        foreach (frame[i]) frame[i] = 8'($urandom);
        if (match) begin
            frame[0] = sb.dev_addr[15:8];
            frame[1] = sb.dev_addr[7:0];
        end else begin
            frame[0] = sb.dev_addr[15:8] ^ (8'h01 << $urandom_range(0, 7));
            frame[1] = sb.dev_addr[7:0];
        end
        issue(OP_START, 1'($urandom_range(0, 1)), 1'b1);
        nbits = full ? FRAME_BYTES * 8 : $urandom_range(1, 20);
        for (int k = 0; k < nbits; k++) begin
            if ($urandom_range(0, 99) < 6)
                issue(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 99) < 2)
                issue(OP_START, 1'($urandom_range(0, 1)), 1'b0);
            issue(OP_CLOCK, frame[k / 8][7 - k % 8], 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_segment(int idle, bit force_match, logic [15:0] addr_a,
                               logic [15:0] per_a, logic [15:0] addr_b, logic [15:0] per_b);
        write_settings(addr_a, per_a);
        sender_idle = idle;
        noise($urandom_range(3, 8));
        send_frame(1'b0, 1'b1);
        send_frame(1'b1, force_match || ($urandom_range(0, 99) < 75));
        // bits past the end of the frame
        repeat ($urandom_range(1, 12))
            issue(OP_CLOCK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        write_settings(addr_b, per_b);
        noise($urandom_range(24, 40));
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_opcode     <= OP_CLOCK;
        i_data_bit   <= 1'b0;
        i_clock_high <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_DEVICE_ADDRESS;
        i_cfg_data   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // power-up pattern across a full scan and the digit wrap
        repeat (7) issue(OP_TICK, 1'b0, 1'b0);
        issue(OP_NONE, 1'b1, 1'b1);
        issue(OP_NONE, 1'b0, 1'b0);
        issue(OP_START, 1'b1, 1'b0);
        issue(OP_START, 1'b0, 1'b1);
        issue(OP_CLOCK, 1'b1, 1'b0);
        issue(OP_CLOCK, 1'b0, 1'b1);
        issue(OP_CLOCK, 1'b1, 1'b1);
        issue(OP_TICK, 1'b1, 1'b1);
        issue(OP_CLOCK, 1'b0, 1'b0);
        issue(OP_START, 1'b1, 1'b1);
        issue(OP_CLOCK, 1'b1, 1'b0);
        repeat (5) issue(OP_TICK, 1'b0, 1'b1);

        run_segment(24, 1'b1, 16'h0000, 16'd1, 16'h0000, 16'd0);
        run_segment(45, 1'b0, 16'hFFFF, 16'd65535, 16'hFFFF, 16'd2);
        run_segment(0, 1'b0, 16'($urandom), 16'($urandom_range(1, 4)),
                    16'($urandom), 16'd3);

        drain();
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
